// ===== rtl/core/srsc_pkg.sv =====
// Shared types and constants for the shadow return-stack checker.
// Depends on nothing; imported by every module of the block but srsc_frame_ram.
package srsc_pkg;

  localparam int STACK_DEPTH = 512;
  localparam int ADDR_WIDTH  = 64;
  localparam int FIELD_W     = 10;
  localparam int GAP_W       = 4;

  localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W  = (PTR_W > FIELD_W) ? PTR_W : FIELD_W;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(7);

  localparam logic OP_CALL   = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_MATCHED   = 3'd1;
  localparam logic [2:0] ST_IGNORED   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;
  localparam logic [2:0] ST_HALTED    = 3'd5;

  typedef struct packed {
    logic        op;
    logic [63:0] address;
    logic        from_main_thread;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [FIELD_W-1:0] frames_skipped;
    logic [FIELD_W-1:0] stack_depth;
  } rsp_t;

endpackage

// ===== rtl/core/srsc_frame_ram.sv =====
// Single-port synchronous RAM holding the stacked call addresses.
// Registered read data; no dependencies.
module srsc_frame_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 64
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/core/srsc_ctrl.sv =====
// Sequencer of the checker: decodes requests, walks the frame RAM on a return
// and holds the result register. Depends on srsc_pkg.
module srsc_ctrl
  import srsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  input  logic [GAP_W-1:0]      max_return_gap,
  output logic                  ram_en,
  output logic                  ram_we,
  output logic [IDX_W-1:0]      ram_addr,
  output logic [ADDR_WIDTH-1:0] ram_wdata,
  input  logic [ADDR_WIDTH-1:0] ram_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_FINISH} state_t;

  state_t                state;
  logic [CNT_W-1:0]      top;
  logic [CNT_W-1:0]      skipped;
  logic                  halted;
  logic [ADDR_WIDTH-1:0] target;
  rsp_t                  pend;

  logic [CNT_W-1:0]      top_dec;
  logic [CNT_W-1:0]      top_inc;
  logic [CNT_W-1:0]      skipped_inc;
  logic                  full;
  logic                  empty;
  logic                  accept;
  logic [ADDR_WIDTH-1:0] diff;
  logic                  gap_ok;
  logic                  is_push;

  assign top_dec     = top - CNT_W'(1);
  assign top_inc     = top + CNT_W'(1);
  assign skipped_inc = skipped + CNT_W'(1);
  assign full        = (top >= CNT_W'(STACK_DEPTH));
  assign empty       = (top == '0);
  assign req_stall   = (state != S_IDLE);
  assign accept      = req_valid && !req_stall;

  assign diff   = target - ram_rdata;
  assign gap_ok = (diff != '0) && (diff <= ADDR_WIDTH'(max_return_gap));

  assign is_push = !halted && req.from_main_thread && (req.op == OP_CALL) && !full;

  // Reads in the pop state are speculative: a match simply ignores them.
  always_comb begin
    ram_we    = accept && is_push;
    ram_en    = ram_we
             || (accept && !halted && req.from_main_thread && (req.op == OP_RETURN) && !empty)
             || ((state == S_POP) && !empty);
    ram_addr  = ram_we ? top[IDX_W-1:0] : top_dec[IDX_W-1:0];
    ram_wdata = req.address[ADDR_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= '0;
      halted    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            target  <= req.address[ADDR_WIDTH-1:0];
            skipped <= '0;
            if (halted) begin
              pend  <= '{ST_HALTED, '0, top[FIELD_W-1:0]};
              state <= S_FINISH;
            end else if (!req.from_main_thread) begin
              pend  <= '{ST_IGNORED, '0, top[FIELD_W-1:0]};
              state <= S_FINISH;
            end else if (req.op == OP_CALL) begin
              state <= S_FINISH;
              if (full) begin
                pend <= '{ST_OVERFLOW, '0, top[FIELD_W-1:0]};
              end else begin
                top  <= top_inc;
                pend <= '{ST_PUSHED, '0, top_inc[FIELD_W-1:0]};
              end
            end else if (empty) begin
              halted <= 1'b1;
              pend   <= '{ST_UNDERFLOW, '0, '0};
              state  <= S_FINISH;
            end else begin
              top   <= top_dec;
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          if (gap_ok) begin
            pend  <= '{ST_MATCHED, skipped[FIELD_W-1:0], top[FIELD_W-1:0]};
            state <= S_FINISH;
          end else if (empty) begin
            halted <= 1'b1;
            pend   <= '{ST_UNDERFLOW, skipped_inc[FIELD_W-1:0], '0};
            state  <= S_FINISH;
          end else begin
            skipped <= skipped_inc;
            top     <= top_dec;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= pend;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/shadow_return_stack_checker_top.sv =====
// Top level of the shadow return-stack checker: gap register, sequencer and
// frame RAM. Depends on srsc_pkg, srsc_ctrl and srsc_frame_ram.
// Usage
//   Request channel (req_valid / req_stall / req): one call or return event.
//   Response channel (rsp_valid / rsp_stall / rsp): exactly one result per
//   request, in request order.
//   cfg_we / cfg_wdata write max_return_gap; write only while the block idles.
// Sequence
//   A call, an ignored or halted event, or a return on an empty stack goes
//   from S_IDLE through S_FINISH to the response register; a return passes
//   through S_POP, staying there for each frame popped without a match, as
//   the single RAM port reads one frame per cycle. A new request is taken
//   the cycle after the response loads. One request is in flight.
// Stalls
//   The response register holds while rsp_stall is high; one more request is
//   taken and its result waits in the sequencer, then the request side stalls.
// Reset
//   rst (synchronous) empties the stack, clears the halt flag and loads the
//   gap with 7. The frame RAM is not cleared: only entries below the stack
//   pointer are read, each written at least one request before its read.
module shadow_return_stack_checker_top
  import srsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [GAP_W-1:0] cfg_wdata
);

  logic [GAP_W-1:0]      max_return_gap;
  logic                  ram_en;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_addr;
  logic [ADDR_WIDTH-1:0] ram_wdata;
  logic [ADDR_WIDTH-1:0] ram_rdata;

  // Hold the gap limit; take a new value on every write strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_return_gap <= GAP_RESET;
    end else if (cfg_we) begin
      max_return_gap <= cfg_wdata;
    end
  end

  // Decode requests, walk the stack and drive the response register.
  srsc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .max_return_gap (max_return_gap),
    .ram_en         (ram_en),
    .ram_we         (ram_we),
    .ram_addr       (ram_addr),
    .ram_wdata      (ram_wdata),
    .ram_rdata      (ram_rdata)
  );

  // Frame storage: one access per cycle, read data registered.
  srsc_frame_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (ADDR_WIDTH)
  ) u_frame_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/core/srsc_checker.sv =====
// Port-level checks for the shadow return-stack checker, bound to the top.
// Depends on srsc_pkg and shadow_return_stack_checker_top.
module srsc_checker
  import srsc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // Reset empties the response register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Only one request in flight: stall right after each accepted request.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while another is in flight");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

  // An underflow always leaves the stack empty.
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_UNDERFLOW) |-> (rsp.stack_depth == '0))
    else $error("underflow with non-empty stack");

  // Only matched and underflow results report skipped frames.
  a_skip_only_on_return: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_MATCHED && rsp.status != ST_UNDERFLOW)
      |-> (rsp.frames_skipped == '0))
    else $error("skipped frames on non-return result");

endmodule

bind shadow_return_stack_checker_top srsc_checker u_srsc_checker (.*);
